// ----- rtl/line_pair_bit_interleaver_macros.svh -----
// ----------------------------------------------------------------------------
// line_pair_bit_interleaver assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_PAIR_BIT_INTERLEAVER_MACROS_SVH
`define LINE_PAIR_BIT_INTERLEAVER_MACROS_SVH

// same-cycle implication
`define LPBI_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPBI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lpbi_pkg.sv -----
// ----------------------------------------------------------------------------
// lpbi_pkg
// Constants, types and helpers for the line pair bit interleaver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpbi_pkg;

    localparam int BYTES_PER_LINE = 21;
    localparam int TILE_ROWS      = 48;
    localparam int ROWS_PER_FRAME = TILE_ROWS * 4;

    localparam int BYTE_W  = 8;
    localparam int GCFG_W  = 4;
    localparam int ROW_W   = 8;
    localparam int CFG_W   = 8;
    localparam int COL_W   = $clog2(BYTES_PER_LINE);
    localparam int IDX_W   = COL_W + 1;
    localparam int DIVIN_W = IDX_W + 1;

    // x / 3 == (x * 43) >> 7 for x < 128
    localparam int DIV3_MUL   = 43;
    localparam int DIV3_SHIFT = 7;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [GCFG_W-1:0] GROUP_FIRST_RST = GCFG_W'(0);
    localparam logic [GCFG_W-1:0] GROUP_FINAL_RST = GCFG_W'(13);
    localparam logic [ROW_W-1:0]  ROW_FIRST_RST   = ROW_W'(0);
    localparam logic [ROW_W-1:0]  ROW_FINAL_RST   = ROW_W'(191);

    typedef enum logic [1:0] {
        CFG_GROUP_FIRST = 2'd0,
        CFG_GROUP_FINAL = 2'd1,
        CFG_ROW_FIRST   = 2'd2,
        CFG_ROW_FINAL   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic              row_end;
        logic              frame_end;
        logic              run_last;
    } beat_t;

    typedef struct packed {
        logic [1:0] mask;
        beat_t      beat_hi;
        beat_t      beat_lo;
    } entry_t;

    function automatic logic [DIVIN_W-1:0] div3(input logic [DIVIN_W-1:0] x);
        logic [DIVIN_W+6:0] p;
        p = (DIVIN_W+7)'(x) * (DIVIN_W+7)'(DIV3_MUL);
        return DIVIN_W'(p >> DIV3_SHIFT);
    endfunction

    // upper-line nibble onto odd bits, current-line nibble onto even bits
    function automatic logic [BYTE_W-1:0] weave(input logic [3:0] up, input logic [3:0] dn);
        return {up[3], dn[3], up[2], dn[2], up[1], dn[1], up[0], dn[0]};
    endfunction

endpackage

// ----- rtl/lpbi_front.sv -----
// ----------------------------------------------------------------------------
// lpbi_front
// Accepts input transactions, tracks position, keeps the upper line and
// forms windowed byte pairs for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpbi_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_accept,
    input  logic [lpbi_pkg::BYTE_W-1:0] pixel_byte,
    input  logic                       frame_start,
    input  logic                       cfg_write,
    input  lpbi_pkg::cfg_index_t       cfg_index,
    input  logic [lpbi_pkg::CFG_W-1:0] cfg_data,
    output logic                       q_push,
    output lpbi_pkg::entry_t           q_entry
);
    import lpbi_pkg::*;

    localparam logic [COL_W-1:0]   COL_LAST = COL_W'(BYTES_PER_LINE - 1);
    localparam logic [ROW_W-1:0]   ROW_LAST = ROW_W'(ROWS_PER_FRAME - 1);
    localparam logic [DIVIN_W-1:0] IDX_LAST = DIVIN_W'(2 * BYTES_PER_LINE - 1);

    logic [BYTE_W-1:0] store_mem [BYTES_PER_LINE];

    logic [COL_W-1:0]  col_reg;
    logic              odd_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [GCFG_W-1:0] gfirst_reg;
    logic [GCFG_W-1:0] gfinal_reg;
    logic [ROW_W-1:0]  rfirst_reg;
    logic [ROW_W-1:0]  rfinal_reg;

    logic [COL_W-1:0]   col_cur;
    logic               odd_cur;
    logic [ROW_W-1:0]   row_cur;
    logic [BYTE_W-1:0]  up_byte;
    logic               row_in;
    logic               last_row;
    logic [DIVIN_W-1:0] gfirst_ext;
    logic [DIVIN_W-1:0] gfinal_ext;
    logic [DIVIN_W-1:0] idx   [2];
    logic [DIVIN_W-1:0] grp   [2];
    logic [DIVIN_W-1:0] grp_n [2];
    logic [1:0]         pass;
    logic [1:0]         rend;

    assign col_cur = frame_start ? '0 : col_reg;
    assign odd_cur = frame_start ? 1'b0 : odd_reg;
    assign row_cur = frame_start ? '0 : row_reg;
    assign up_byte = store_mem[col_cur];

    assign row_in     = (row_cur >= rfirst_reg) && (row_cur <= rfinal_reg);
    assign last_row   = (row_cur >= rfinal_reg) || (row_cur == ROW_LAST);
    assign gfirst_ext = DIVIN_W'(gfirst_reg);
    assign gfinal_ext = DIVIN_W'(gfinal_reg);

    always_comb
    begin
        for (int h = 0; h < 2; h++)
        begin
            idx[h]   = DIVIN_W'({col_cur, 1'b0}) + DIVIN_W'(h);
            grp[h]   = div3(idx[h]);
            grp_n[h] = div3(idx[h] + DIVIN_W'(1));
            pass[h]  = row_in && (grp[h] >= gfirst_ext) && (grp[h] <= gfinal_ext);
            rend[h]  = (idx[h] == IDX_LAST) || (grp_n[h] > gfinal_ext);
        end
    end

    always_comb
    begin
        q_entry.mask               = {pass[1], pass[0]};
        q_entry.beat_hi.byte_val   = weave(up_byte[7:4], pixel_byte[7:4]);
        q_entry.beat_hi.row_end    = rend[0];
        q_entry.beat_hi.frame_end  = rend[0] && last_row;
        q_entry.beat_hi.run_last   = !pass[1];
        q_entry.beat_lo.byte_val   = weave(up_byte[3:0], pixel_byte[3:0]);
        q_entry.beat_lo.row_end    = rend[1];
        q_entry.beat_lo.frame_end  = rend[1] && last_row;
        q_entry.beat_lo.run_last   = 1'b1;
    end

    assign q_push = in_accept && odd_cur && (|pass);

    always_ff @(posedge clk)
    begin
        if (in_accept && !odd_cur)
        begin
            store_mem[col_cur] <= pixel_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            odd_reg <= 1'b0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            if (col_cur == COL_LAST)
            begin
                col_reg <= '0;
                odd_reg <= !odd_cur;
                if (odd_cur)
                begin
                    row_reg <= (row_cur == ROW_LAST) ? '0 : row_cur + ROW_W'(1);
                end
                else
                begin
                    row_reg <= row_cur;
                end
            end
            else
            begin
                col_reg <= col_cur + COL_W'(1);
                odd_reg <= odd_cur;
                row_reg <= row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gfirst_reg <= GROUP_FIRST_RST;
            gfinal_reg <= GROUP_FINAL_RST;
            rfirst_reg <= ROW_FIRST_RST;
            rfinal_reg <= ROW_FINAL_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_GROUP_FIRST: gfirst_reg <= cfg_data[GCFG_W-1:0];
                CFG_GROUP_FINAL: gfinal_reg <= cfg_data[GCFG_W-1:0];
                CFG_ROW_FIRST:   rfirst_reg <= cfg_data[ROW_W-1:0];
                CFG_ROW_FINAL:   rfinal_reg <= cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/lpbi_queue.sv -----
// ----------------------------------------------------------------------------
// lpbi_queue
// Short entry queue between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpbi_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lpbi_pkg::entry_t wr_entry,
    input  logic             pop,
    output lpbi_pkg::entry_t rd_entry,
    output logic             full,
    output logic             empty
);
    import lpbi_pkg::*;

    `include "line_pair_bit_interleaver_macros.svh"

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t           slot_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign rd_entry = slot_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `LPBI_ASSERT_IMPLY(a_q_no_overflow, push, !full, "queue push while full")
    `LPBI_ASSERT_IMPLY(a_q_no_underflow, pop, !empty, "queue pop while empty")

endmodule

// ----- rtl/lpbi_back.sv -----
// ----------------------------------------------------------------------------
// lpbi_back
// Serializes queued byte pairs onto the one-byte result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpbi_back (
    input  logic             clk,
    input  logic             rst_n,
    input  lpbi_pkg::entry_t q_entry,
    input  logic             q_empty,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output lpbi_pkg::beat_t  out_beat
);
    import lpbi_pkg::*;

    `include "line_pair_bit_interleaver_macros.svh"

    logic  out_valid_reg;
    logic  out_valid_next;
    beat_t out_beat_reg;
    beat_t out_beat_next;
    logic  pend_valid_reg;
    logic  pend_valid_next;
    beat_t pend_beat_reg;
    beat_t pend_beat_next;
    logic  load;

    assign load     = !out_valid_reg || pop;
    assign q_pop    = load && !pend_valid_reg && !q_empty;
    assign empty    = !out_valid_reg;
    assign out_beat = out_beat_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_beat_next   = out_beat_reg;
        pend_valid_next = pend_valid_reg;
        pend_beat_next  = pend_beat_reg;
        if (load)
        begin
            priority if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_beat_next   = pend_beat_reg;
                pend_valid_next = 1'b0;
            end
            else if (!q_empty)
            begin
                out_valid_next = 1'b1;
                if (q_entry.mask[0])
                begin
                    out_beat_next   = q_entry.beat_hi;
                    pend_valid_next = q_entry.mask[1];
                    pend_beat_next  = q_entry.beat_lo;
                end
                else
                begin
                    out_beat_next = q_entry.beat_lo;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg  <= out_beat_next;
        pend_beat_reg <= pend_beat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    `LPBI_ASSERT_IMPLY(a_pend_behind_out, pend_valid_reg, out_valid_reg,
                       "pending byte without an output byte")
    `LPBI_ASSERT_IMPLY(a_entry_not_blank, q_pop, q_entry.mask != 2'b00,
                       "queue entry without a passed byte")
    `LPBI_ASSERT_IMPLY(a_frame_end_row_end, out_valid_reg && out_beat_reg.frame_end,
                       out_beat_reg.row_end, "frame end without row end")

endmodule

// ----- rtl/line_pair_bit_interleaver.sv -----
// ----------------------------------------------------------------------------
// line_pair_bit_interleaver
// Interleaves line pairs of a 1 bpp frame into windowed output rows.
// ----------------------------------------------------------------------------
// Input channel: push / full with pixel_byte and frame_start; a transaction
// completes when push is high and full is low. Bytes come in line order,
// 21 per line. Even lines are stored; each odd-line byte yields up to two
// interleaved bytes, filtered by the row and group window.
// Result channel: empty / pop with out_byte, row_end, frame_end, run_last;
// the oldest byte is shown while empty is low, taken when pop is high.
// Config: cfg_write, cfg_index, cfg_data write one window register per cycle.
// A result passes through the queue and then the output register before it shows.
// Throughput: one input per cycle on even lines while full is low; on odd
// lines one output byte per cycle leaves the output register while pop is high.
// A two-entry queue decouples input from output; when pop stays low the
// queue fills and full rises, holding off input.
// Reset: counters clear, window returns to the full frame, queue and output
// empty. The line store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_pair_bit_interleaver (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [lpbi_pkg::BYTE_W-1:0] pixel_byte,
    input  logic                        frame_start,
    output logic                        empty,
    input  logic                        pop,
    output logic [lpbi_pkg::BYTE_W-1:0] out_byte,
    output logic                        row_end,
    output logic                        frame_end,
    output logic                        run_last,
    input  logic                        cfg_write,
    input  lpbi_pkg::cfg_index_t        cfg_index,
    input  logic [lpbi_pkg::CFG_W-1:0]  cfg_data
);
    import lpbi_pkg::*;

    logic   in_accept;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    entry_t q_wr_entry;
    entry_t q_rd_entry;
    beat_t  out_beat;

    assign full      = q_full;
    assign in_accept = push && !q_full;

    lpbi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .pixel_byte  (pixel_byte),
        .frame_start (frame_start),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_push      (q_push),
        .q_entry     (q_wr_entry)
    );

    lpbi_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .pop      (q_pop),
        .rd_entry (q_rd_entry),
        .full     (q_full),
        .empty    (q_empty)
    );

    lpbi_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_entry  (q_rd_entry),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_beat (out_beat)
    );

    assign out_byte  = out_beat.byte_val;
    assign row_end   = out_beat.row_end;
    assign frame_end = out_beat.frame_end;
    assign run_last  = out_beat.run_last;

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line pair bit interleaver.
// ----------------------------------------------------------------------------
// Pixel bytes go in through the push/full port and interleaved bytes come out
// through the empty/pop port. A scoreboard keeps its own line store, column,
// row and window state. For every input transaction it computes the bytes the
// block must emit and queues them. Each popped byte is compared field by
// field against the oldest queued one. Stimulus starts with a directed line
// pair of extreme patterns. Random traffic follows under several windows:
// wide, empty, narrow and beyond the frame. The traffic is mostly framed line
// pairs, with loose lines and noisy frame starts mixed in. A final short run
// of framed line pairs ends the frame early through the row window. Both sides
// stall at random up to the last traffic pass; each window change awaits a drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import lpbi_pkg::*;

    localparam int STALL_LIMIT = 2000;

    class weave_scoreboard;
        logic [BYTE_W-1:0] upper_line [BYTES_PER_LINE];
        int unsigned       column;
        int unsigned       pair_row;
        bit                odd_line;
        logic [GCFG_W-1:0] grp_first;
        logic [GCFG_W-1:0] grp_final;
        logic [ROW_W-1:0]  row_first;
        logic [ROW_W-1:0]  row_final;
        beat_t             awaited[$];
        int                failures;

        function new();
            column    = 0;
            pair_row  = 0;
            odd_line  = 1'b0;
            grp_first = GROUP_FIRST_RST;
            grp_final = GROUP_FINAL_RST;
            row_first = ROW_FIRST_RST;
            row_final = ROW_FINAL_RST;
            failures  = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_GROUP_FIRST: grp_first = val[GCFG_W-1:0];
                CFG_GROUP_FINAL: grp_final = val[GCFG_W-1:0];
                CFG_ROW_FIRST:   row_first = val[ROW_W-1:0];
                CFG_ROW_FINAL:   row_final = val[ROW_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_pixel(logic [BYTE_W-1:0] pix, logic fs);
            int unsigned       col;
            int unsigned       idx;
            int unsigned       grp;
            int                h;
            int                k;
            int                n;
            logic [BYTE_W-1:0] up;
            logic [BYTE_W-1:0] b;
            logic [3:0]        un;
            logic [3:0]        cn;
            bit                row_in;
            bit                last_row;
            bit                rend;
            beat_t             made [2];

            if (fs)
            begin
                column   = 0;
                odd_line = 1'b0;
                pair_row = 0;
            end
            col = column;
            n   = 0;
            if (!odd_line)
            begin
                upper_line[col] = pix;
            end
            else
            begin
                up       = upper_line[col];
                row_in   = pair_row >= row_first && pair_row <= row_final;
                last_row = pair_row >= row_final || pair_row == ROWS_PER_FRAME - 1;
                for (h = 0; h < 2; h++)
                begin
                    un = h ? up[3:0] : up[7:4];
                    cn = h ? pix[3:0] : pix[7:4];
                    for (k = 0; k < 4; k++)
                    begin
                        b[2*k+1] = un[k];
                        b[2*k]   = cn[k];
                    end
                    idx = 2 * col + h;
                    grp = idx / 3;
                    if (row_in && grp >= grp_first && grp <= grp_final)
                    begin
                        rend = idx == 2 * BYTES_PER_LINE - 1 || (idx + 1) / 3 > grp_final;
                        made[n].byte_val  = b;
                        made[n].row_end   = rend;
                        made[n].frame_end = rend && last_row;
                        made[n].run_last  = 1'b0;
                        n++;
                    end
                end
                if (n > 0)
                    made[n-1].run_last = 1'b1;
                for (k = 0; k < n; k++)
                    awaited.push_back(made[k]);
            end

            column = col + 1;
            if (column >= BYTES_PER_LINE)
            begin
                column = 0;
                if (odd_line)
                begin
                    pair_row++;
                    if (pair_row >= ROWS_PER_FRAME)
                        pair_row = 0;
                end
                odd_line = !odd_line;
            end
        endfunction

        function void check_beat(beat_t got);
            beat_t want;
            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected byte: out_byte=%02h row_end=%0b frame_end=%0b run_last=%0b",
                             got.byte_val, got.row_end, got.frame_end, got.run_last);
            end
            else
            begin
                want = awaited.pop_front();
                if (got.byte_val !== want.byte_val || got.row_end !== want.row_end ||
                    got.frame_end !== want.frame_end || got.run_last !== want.run_last)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("mismatch: exp %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                                 want.byte_val, want.row_end, want.frame_end, want.run_last,
                                 got.byte_val, got.row_end, got.frame_end, got.run_last);
                end
            end
        endfunction
    endclass

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              push        = 1'b0;
    logic              full;
    logic [BYTE_W-1:0] pixel_byte  = '0;
    logic              frame_start = 1'b0;
    logic              empty;
    logic              pop         = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic              row_end;
    logic              frame_end;
    logic              run_last;
    logic              cfg_write   = 1'b0;
    cfg_index_t        cfg_index   = CFG_GROUP_FIRST;
    logic [CFG_W-1:0]  cfg_data    = '0;

    weave_scoreboard   sb;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                stall_cycles  = 0;

    line_pair_bit_interleaver u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel_byte  (pixel_byte),
        .frame_start (frame_start),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .row_end     (row_end),
        .frame_end   (frame_end),
        .run_last    (run_last),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                sb.check_beat(beat_t'({out_byte, row_end, frame_end, run_last}));
            if (push && !full)
                sb.take_pixel(pixel_byte, frame_start);
            if (cfg_write)
                sb.set_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_write)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("** line_pair_bit_interleaver: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] pix, input logic fs);
        if ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        push        <= 1'b1;
        pixel_byte  <= pix;
        frame_start <= fs;
        do
            @(posedge clk);
        while (full);
    endtask

    // hold off input until every expected byte has been popped
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_window(input logic [CFG_W-1:0] gf, gl, rf, rl);
        logic [CFG_W-1:0] vals [4];
        vals = '{gf, gl, rf, rl};
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    // framed line pairs, loose lines and noise with stray frame starts
    task automatic run_traffic(input int n);
        int   sent;
        int   kind;
        int   len;
        logic fs;
        sent = 0;
        while (sent < n)
        begin
            kind = $urandom_range(9);
            if (kind < 6)
                len = 2 * BYTES_PER_LINE * $urandom_range(1, 2);
            else if (kind < 9)
                len = BYTES_PER_LINE * $urandom_range(1, 3);
            else
                len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
            begin
                fs = (kind < 6 && i == 0) || (kind == 9 && $urandom_range(7) == 0);
                send_byte(BYTE_W'($urandom_range(255)), fs);
            end
            sent += len;
        end
    endtask

    task automatic pick_window(input int slot);
        logic [CFG_W-1:0] gf;
        logic [CFG_W-1:0] gl;
        logic [CFG_W-1:0] rf;
        logic [CFG_W-1:0] rl;
        gf = CFG_W'($urandom_range(255));
        gl = CFG_W'($urandom_range(255));
        rf = CFG_W'($urandom_range(6));
        case ($urandom_range(3))
            0: rl = CFG_W'($urandom_range(8));
            1: rl = CFG_W'(ROWS_PER_FRAME - 1);
            2: rl = 8'hFF;
            default: rl = CFG_W'($urandom_range(255));
        endcase
        case (slot)
            0: set_window(8'h00, 8'hFF, 8'h00, 8'hFF);
            1: set_window({gf[7:4], 4'd9}, {gl[7:4], 4'd4}, rf, rl);
            2: set_window(8'h00, 8'h0D, 8'd5, 8'd2);
            3: set_window(gf, gf, rf, rl);
            default: set_window(gf, gl, rf, rl);
        endcase
    endtask

    initial
    begin
        logic [BYTE_W-1:0] pattern [7];
        pattern = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h81};
        sb = new();
        send_idle_pct = 29;
        recv_idle_pct = 51;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window: one line pair crossing every extreme pattern
        for (int i = 0; i < 2 * BYTES_PER_LINE; i++)
        begin
            if (i < BYTES_PER_LINE)
                send_byte(pattern[i % 7], i == 0);
            else
                send_byte(pattern[(i / 7 + i) % 7], 1'b0);
        end
        settle();

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 51 : 0;
            recv_idle_pct = (mode == 0) ? 51 : (mode == 1) ? 29 : 0;
            for (int slot = 0; slot < 6; slot++)
            begin
                pick_window(slot);
                run_traffic(60);
                settle();
            end
        end

        // three framed line pairs: frame end from the row window,
        // the third row falls outside it
        set_window(8'h0D, 8'h0F, 8'h00, 8'h01);
        for (int i = 0; i < 3 * 2 * BYTES_PER_LINE; i++)
            send_byte(BYTE_W'($urandom_range(255)), i == 0);
        settle();

        if (sb.failures == 0 && sb.awaited.size() == 0)
            $display("** line_pair_bit_interleaver: PASSED **");
        else
            $display("** line_pair_bit_interleaver: FAILED **");
        $finish;
    end

endmodule
